[src/ffd_pkg.sv]
// ----------------------------------------------------------------------------
// ffd_pkg
// shared types and constants for the fixed frame deframer with xor check
// ----------------------------------------------------------------------------
`default_nettype none

package ffd_pkg;

  typedef logic [7:0] byte_t;

  // body bytes after the header: id, command, data high, data low, check, end
  localparam int unsigned BODY_LEN    = 6;
  // the last body byte is used straight from the input register
  localparam int unsigned STORE_DEPTH = BODY_LEN - 1;
  localparam int unsigned COUNT_W     = $clog2(BODY_LEN);

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef logic [COUNT_W-1:0]                 count_t;
  typedef logic [STORE_DEPTH-1:0][7:0]        body_t;

  localparam count_t LAST_COUNT = count_t'(STORE_DEPTH);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HEADER_VALUE = 2'd0,
    CFG_END_VALUE    = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_GOOD      = 2'd0,
    STATUS_BAD_END   = 2'd1,
    STATUS_BAD_CHECK = 2'd2
  } status_t;

  // positions in the body store
  localparam int unsigned POS_DEVICE_ID = 0;
  localparam int unsigned POS_COMMAND   = 1;
  localparam int unsigned POS_DATA_HI   = 2;
  localparam int unsigned POS_DATA_LO   = 3;
  localparam int unsigned POS_CHECK     = 4;

  localparam byte_t HEADER_RESET = 8'd170;
  localparam byte_t END_RESET    = 8'd85;

endpackage

`default_nettype wire

[src/ffd_byte_if.sv]
// ----------------------------------------------------------------------------
// ffd_byte_if
// valid/ready channel carrying one received byte per item
// ----------------------------------------------------------------------------
`default_nettype none

interface ffd_byte_if import ffd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[src/ffd_result_if.sv]
// ----------------------------------------------------------------------------
// ffd_result_if
// valid/ready channel carrying one decoded frame per item
// ----------------------------------------------------------------------------
`default_nettype none

interface ffd_result_if import ffd_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  byte_t       device_id;
  byte_t       command;
  logic [15:0] payload;

  modport source (output valid, output status, output device_id, output command,
                  output payload, input ready);
  modport sink   (input valid, input status, input device_id, input command,
                  input payload, output ready);
endinterface

`default_nettype wire

[src/ffd_frame_check.sv]
// ----------------------------------------------------------------------------
// ffd_frame_check
// end marker and xor checksum test on a completed frame body
// ----------------------------------------------------------------------------
`default_nettype none

module ffd_frame_check import ffd_pkg::*; (
  input  body_t   body,
  input  byte_t   last_byte,
  input  byte_t   end_value,
  output status_t status
);

  byte_t chk;

  assign chk = body[POS_DEVICE_ID] ^ body[POS_COMMAND] ^
               body[POS_DATA_HI] ^ body[POS_DATA_LO];

  // end marker takes priority over the checksum
  always_comb begin
    if (last_byte != end_value) begin
      status = STATUS_BAD_END;
    end else if (chk != body[POS_CHECK]) begin
      status = STATUS_BAD_CHECK;
    end else begin
      status = STATUS_GOOD;
    end
  end

endmodule

`default_nettype wire

[src/fixed_frame_deframer_xor_check.sv]
// ----------------------------------------------------------------------------
// fixed_frame_deframer_xor_check
// hunts for a header byte, collects a six byte body and reports one frame
// ----------------------------------------------------------------------------
// Takes one byte per cycle while rx.ready is high, with no gaps needed. Each
// byte goes into an input register and is decoded against the frame position
// counter once the result register is free or being drained, and a completed
// frame lands in the result register. rx.ready only drops while the
// input register is full and the result register holds a frame that has not
// been taken. Bytes before a header are dropped; a header byte inside a frame
// is ordinary data. Status is 0 for a good frame, 1 for a bad end marker
// (reported even if the checksum also fails) and 2 for a checksum mismatch;
// the frame fields are always the received bytes. header_value (index 0) and
// end_value (index 1) should only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_frame_deframer_xor_check import ffd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  ffd_byte_if.sink                    rx,
  ffd_result_if.source                frame
);

  byte_t   header_value;
  byte_t   end_value;

  logic    in_valid;
  byte_t   in_byte;

  logic    in_frame;
  count_t  byte_count;
  body_t   frame_store;

  logic    advance;
  logic    consume;
  logic    last_byte;
  status_t status_next;

  // input register can move on when the result register is free or draining
  assign advance   = !frame.valid || frame.ready;
  assign consume   = in_valid && advance;
  assign rx.ready  = !in_valid || advance;
  assign last_byte = in_frame && (byte_count == LAST_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
      end_value    <= END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_VALUE: header_value <= cfg_data;
        CFG_END_VALUE:    end_value    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else if (consume) begin
      if (!in_frame) begin
        if (in_byte == header_value) begin
          in_frame   <= 1'b1;
          byte_count <= '0;
        end
      end else if (last_byte) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + count_t'(1);
      end
    end
  end

  // body store, written one byte per position
  always_ff @(posedge clk) begin
    if (consume && in_frame && !last_byte) begin
      frame_store[byte_count] <= in_byte;
    end
  end

  ffd_frame_check u_check (
    .body      (frame_store),
    .last_byte (in_byte),
    .end_value (end_value),
    .status    (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (consume && last_byte) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && last_byte) begin
      frame.status    <= status_next;
      frame.device_id <= frame_store[POS_DEVICE_ID];
      frame.command   <= frame_store[POS_COMMAND];
      frame.payload   <= {frame_store[POS_DATA_HI], frame_store[POS_DATA_LO]};
    end
  end

  // a new frame only follows the final body byte
  a_frame_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(frame.valid) |-> $past(consume && last_byte))
    else $error("frame raised without a final body byte");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LAST_COUNT)
    else $error("byte count beyond last body position");

  a_hunt_count_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> byte_count == '0)
    else $error("byte count not cleared while hunting");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !frame.valid |-> rx.ready)
    else $error("input stalled with an empty result register");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (consume && in_frame && !last_byte) |=> byte_count == $past(byte_count) + count_t'(1))
    else $error("byte count did not step on a body byte");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the fixed frame deframer with xor check
// ----------------------------------------------------------------------------
// Feeds received bytes through the byte channel and checks every decoded frame
// against an in-bench frame predictor. A short table of hand-made frames comes
// first, then mostly well-formed frames with random content, mixed with noise
// and cut-short frames, over several header and end marker settings. Both
// channels idle at random, the result side is held off for a long stretch once
// and the byte side pauses once until every frame has come out.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import ffd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    byte_t       device_id;
    byte_t       command;
    logic [15:0] payload;
  } frame_rec_t;

  typedef struct packed {
    byte_t      rx_byte;
    bit         typed;
    frame_rec_t result;
  } dir_row_t;

  typedef enum {EV_NONE, EV_HOLD, EV_PAUSE} phase_event_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BYTES    = 210;
  localparam int DIR_ROWS       = 22;

  localparam frame_rec_t NO_FRAME = '{STATUS_GOOD, 8'h00, 8'h00, 16'h0000};

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // noise while hunting
    '{8'h55, 1'b0, NO_FRAME},
    // good frame, header value reused as data
    '{8'hAA, 1'b0, NO_FRAME},
    '{8'hAA, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h12, 1'b0, NO_FRAME},
    '{8'h47, 1'b0, NO_FRAME},
    '{8'h55, 1'b1, '{STATUS_GOOD, 8'hAA, 8'hFF, 16'h0012}},
    // bad end marker wins over a bad check byte
    '{8'hAA, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h00, 1'b0, NO_FRAME},
    '{8'h01, 1'b0, NO_FRAME},
    '{8'h00, 1'b1, '{STATUS_BAD_END, 8'h00, 8'h00, 16'h0000}},
    // checksum mismatch, all ones
    '{8'hAA, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'hFF, 1'b0, NO_FRAME},
    '{8'h01, 1'b0, NO_FRAME},
    '{8'h55, 1'b1, '{STATUS_BAD_CHECK, 8'hFF, 8'hFF, 16'hFFFF}}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ffd_byte_if   rx_ch ();
  ffd_result_if frame_ch ();

  fixed_frame_deframer_xor_check u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .frame     (frame_ch)
  );

  // predictor state and its copy of the registers
  byte_t      hdr_byte;
  byte_t      eom_byte;
  bit         framing;
  logic [2:0] body_pos;
  byte_t      body_bytes [BODY_LEN];

  frame_rec_t frames_due [$];
  int         errors;
  int         phase_bytes;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_request;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit deframe_byte(input byte_t b, output frame_rec_t f);
    byte_t chk;
    f = NO_FRAME;
    if (!framing) begin
      if (b == hdr_byte) begin
        framing  = 1'b1;
        body_pos = 3'd0;
      end
      return 1'b0;
    end
    // a count past the body drops the frame
    if (body_pos >= BODY_LEN) begin
      framing  = 1'b0;
      body_pos = 3'd0;
      return 1'b0;
    end
    body_bytes[body_pos] = b;
    body_pos = body_pos + 3'd1;
    if (body_pos < BODY_LEN) return 1'b0;
    chk = body_bytes[POS_DEVICE_ID] ^ body_bytes[POS_COMMAND] ^
          body_bytes[POS_DATA_HI] ^ body_bytes[POS_DATA_LO];
    if (body_bytes[BODY_LEN-1] != eom_byte) f.status = STATUS_BAD_END;
    else if (chk != body_bytes[POS_CHECK]) f.status = STATUS_BAD_CHECK;
    else f.status = STATUS_GOOD;
    f.device_id = body_bytes[POS_DEVICE_ID];
    f.command   = body_bytes[POS_COMMAND];
    f.payload   = {body_bytes[POS_DATA_HI], body_bytes[POS_DATA_LO]};
    framing  = 1'b0;
    body_pos = 3'd0;
    return 1'b1;
  endfunction

  // entered and left at a falling edge; valid stays up on exit
  task automatic send_byte(input byte_t b, input bit typed, input frame_rec_t typed_frame);
    frame_rec_t predicted;
    bit         got;
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    got = deframe_byte(b, predicted);
    if (typed) frames_due.push_back(typed_frame);
    else if (got) frames_due.push_back(predicted);
    phase_bytes++;
    @(negedge clk);
  endtask

  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input byte_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_HEADER_VALUE) hdr_byte = val;
    else if (idx == CFG_END_VALUE) eom_byte = val;
  endtask

  task automatic send_sequence();
    byte_t id, cmd, hi, lo, chk, eom;
    int    roll, n;
    roll = $urandom_range(99);
    if (roll < 80) begin
      id  = byte_t'($urandom);
      cmd = byte_t'($urandom);
      hi  = byte_t'($urandom);
      lo  = byte_t'($urandom);
      chk = id ^ cmd ^ hi ^ lo;
      if ($urandom_range(99) < 35) chk = byte_t'($urandom);
      eom = ($urandom_range(99) < 75) ? eom_byte : byte_t'($urandom);
      send_byte(hdr_byte, 1'b0, NO_FRAME);
      send_byte(id, 1'b0, NO_FRAME);
      send_byte(cmd, 1'b0, NO_FRAME);
      send_byte(hi, 1'b0, NO_FRAME);
      send_byte(lo, 1'b0, NO_FRAME);
      send_byte(chk, 1'b0, NO_FRAME);
      send_byte(eom, 1'b0, NO_FRAME);
    end else if (roll < 90) begin
      n = $urandom_range(4, 1);
      repeat (n) send_byte(byte_t'($urandom), 1'b0, NO_FRAME);
    end else begin
      // frame cut short, the next bytes run on into its body
      n = $urandom_range(5, 1);
      send_byte(hdr_byte, 1'b0, NO_FRAME);
      repeat (n) send_byte(byte_t'($urandom), 1'b0, NO_FRAME);
    end
  endtask

  task automatic random_phase(input phase_event_t ev);
    bit fired;
    fired       = 1'b0;
    phase_bytes = 0;
    while (phase_bytes < PHASE_BYTES) begin
      send_sequence();
      if (!fired && phase_bytes >= PHASE_BYTES / 2) begin
        fired = 1'b1;
        if (ev == EV_HOLD) begin
          hold_request = 1'b1;
        end else if (ev == EV_PAUSE) begin
          rx_ch.valid <= 1'b0;
          while (frames_due.size() != 0) @(negedge clk);
        end
      end
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left      = 0;
    frame_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    frame_rec_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (frames_due.size() == 0) begin
        $error("frame with nothing expected: status %0d device_id %0h command %0h payload %0h",
               frame_ch.status, frame_ch.device_id, frame_ch.command, frame_ch.payload);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (frame_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, frame_ch.status);
          errors++;
        end
        if (frame_ch.device_id !== want.device_id) begin
          $error("device_id: expected %0h, got %0h", want.device_id, frame_ch.device_id);
          errors++;
        end
        if (frame_ch.command !== want.command) begin
          $error("command: expected %0h, got %0h", want.command, frame_ch.command);
          errors++;
        end
        if (frame_ch.payload !== want.payload) begin
          $error("payload: expected %0h, got %0h", want.payload, frame_ch.payload);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_HEADER_VALUE;
    cfg_data      = 8'h00;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    errors        = 0;
    idle_cycles   = 0;
    hold_request  = 1'b0;
    hdr_byte      = HEADER_RESET;
    eom_byte      = END_RESET;
    framing       = 1'b0;
    body_pos      = 3'd0;
    send_idle_pct = 10;
    recv_idle_pct = 55;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIRECTED[i].rx_byte, DIRECTED[i].typed, DIRECTED[i].result);
    settle();

    // writes past the register list must leave the reset values alone
    cfg_write(CFG_SPARE_A, 8'h00);
    cfg_write(CFG_SPARE_B, 8'hFF);
    random_phase(EV_NONE);
    settle();

    cfg_write(CFG_HEADER_VALUE, 8'h00);
    cfg_write(CFG_END_VALUE, 8'hFF);
    random_phase(EV_HOLD);
    settle();

    send_idle_pct = 55;
    recv_idle_pct = 10;
    cfg_write(CFG_HEADER_VALUE, 8'hFF);
    cfg_write(CFG_END_VALUE, 8'h00);
    random_phase(EV_PAUSE);
    settle();

    cfg_write(CFG_HEADER_VALUE, byte_t'($urandom));
    cfg_write(CFG_END_VALUE, byte_t'($urandom));
    random_phase(EV_NONE);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(CFG_HEADER_VALUE, byte_t'($urandom));
    cfg_write(CFG_END_VALUE, byte_t'($urandom));
    random_phase(EV_NONE);
    settle();

    cfg_write(CFG_HEADER_VALUE, HEADER_RESET);
    cfg_write(CFG_END_VALUE, END_RESET);
    random_phase(EV_NONE);
    settle();

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
